[src/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int BUF_AW      = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(WRITE_DEPTH + 1);

  localparam int KIND_W = 2;
  localparam int DEV_W  = 7;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN_WR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BEGIN_RD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_NONE    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TIMEOUT = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_REJECT  = 2'd3;

  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_BEGIN_WR,
    OP_BEGIN_RD,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              sda;
    logic [DEV_W-1:0]  dev;
    logic [BYTE_W-1:0] reg_addr;
    logic [LEN_W-1:0]  len;
    logic              len_fits;
    logic [BYTE_W-1:0] wbyte;
  } cmd_t;

endpackage

[src/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: decodes the beat kind into an operation and pushes the
// classified command into the queue.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [i2cm_pkg::KIND_W-1:0] in_kind,
  input  logic                      in_sda_in,
  input  logic [i2cm_pkg::DEV_W-1:0]  in_dev_address,
  input  logic [i2cm_pkg::BYTE_W-1:0] in_reg_address,
  input  logic [i2cm_pkg::LEN_W-1:0]  in_length,
  input  logic [i2cm_pkg::BYTE_W-1:0] in_write_byte,
  input  logic                      q_full,
  output logic                      push,
  output i2cm_pkg::cmd_t            push_data
);
  import i2cm_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data          = '0;
    push_data.sda      = in_sda_in;
    push_data.dev      = in_dev_address;
    push_data.reg_addr = in_reg_address;
    push_data.len      = in_length;
    push_data.len_fits = (in_length <= LEN_W'(WRITE_DEPTH));
    push_data.wbyte    = in_write_byte;
    case (in_kind)
      KIND_TICK:     push_data.op = OP_TICK;
      KIND_BEGIN_WR: push_data.op = OP_BEGIN_WR;
      KIND_BEGIN_RD: push_data.op = OP_BEGIN_RD;
      KIND_LOAD:     push_data.op = OP_LOAD;
      default:       push_data.op = OP_TICK;
    endcase
  end

endmodule

[src/i2cm_queue.sv]
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry command queue between the front and the bus engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output i2cm_pkg::cmd_t pop_data,
  output logic           not_empty
);
  import i2cm_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/i2cm_engine.sv]
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus engine: phase sequencer, write buffer, timeout register and the
// registered result stage.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  i2cm_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [i2cm_pkg::BYTE_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_scl_level,
  output logic                        out_sda_level,
  output logic                        out_busy_res,
  output logic [i2cm_pkg::BYTE_W-1:0] out_read_byte,
  output logic                        out_read_valid,
  output logic                        out_read_last,
  output logic [i2cm_pkg::STAT_W-1:0] out_status
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START1, PH_START2, PH_TX_BIT, PH_TX_HIGH, PH_TX_LOW,
    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_WAIT, PH_RS1, PH_RS2, PH_RS3, PH_RS4,
    PH_RX_LOW, PH_RX_HIGH, PH_RX_SAMPLE, PH_MACK_DRIVE, PH_MACK_HIGH,
    PH_MACK_LOW, PH_STOP1, PH_STOP2, PH_STOP3
  } phase_t;

  typedef enum logic [1:0] {
    ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA
  } stage_t;

  phase_t            phase_r, phase_nxt;
  stage_t            stage_r, stage_nxt;
  logic [3:0]        bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [LEN_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [BYTE_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [DEV_W-1:0]  tgt_addr_r, tgt_addr_nxt;
  logic [BYTE_W-1:0] tgt_reg_r, tgt_reg_nxt;
  logic              is_read_r, is_read_nxt;
  logic [LEN_W-1:0]  xfer_len_r, xfer_len_nxt;
  logic              failed_r, failed_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [BYTE_W-1:0] ack_timeout_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] rbyte_r, rbyte;
  logic              rvalid_r, rvalid;
  logic              rlast_r, rlast;
  logic [STAT_W-1:0] status_r, status;
  logic              busy_r;

  logic [BYTE_W-1:0] buf_mem [WRITE_DEPTH];
  logic              buf_we;

  logic              go;
  logic [LEN_W-1:0]  bc_inc;
  logic [CNT_W-1:0]  ptr_inc;
  logic [LEN_W-1:0]  sel_bc;
  logic [CNT_W-1:0]  sel_ptr;
  logic              avail;
  logic [BYTE_W-1:0] buf_rd;
  logic [3:0]        bit_inc;
  logic              last_byte;

  assign cmd_pop   = cmd_valid && (!out_valid_r || out_ready);
  assign go        = cmd_pop;
  assign cfg_ready = 1'b1;

  // next data byte: after a data ACK the counters move on, so look one ahead
  assign bc_inc    = byte_cnt_r + LEN_W'(1);
  assign ptr_inc   = rd_ptr_r + CNT_W'(1);
  assign sel_bc    = (stage_r == ST_DATA) ? bc_inc : byte_cnt_r;
  assign sel_ptr   = (stage_r == ST_DATA) ? ptr_inc : rd_ptr_r;
  assign avail     = (sel_bc < xfer_len_r) && (sel_ptr < fill_r);
  assign buf_rd    = buf_mem[sel_ptr[BUF_AW-1:0]];
  assign bit_inc   = bit_cnt_r + 4'd1;
  assign last_byte = ({1'b0, byte_cnt_r} + (LEN_W+1)'(1)) >= {1'b0, xfer_len_r};

  always_comb begin
    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_cnt_nxt = byte_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    fill_nxt     = fill_r;
    rd_ptr_nxt   = rd_ptr_r;
    tgt_addr_nxt = tgt_addr_r;
    tgt_reg_nxt  = tgt_reg_r;
    is_read_nxt  = is_read_r;
    xfer_len_nxt = xfer_len_r;
    failed_nxt   = failed_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    rbyte        = '0;
    rvalid       = 1'b0;
    rlast        = 1'b0;
    status       = STATUS_NONE;
    buf_we       = 1'b0;

    if (go) begin
      case (cmd.op)
        OP_BEGIN_WR, OP_BEGIN_RD: begin
          if (phase_r != PH_IDLE || (cmd.op == OP_BEGIN_WR &&
              (!cmd.len_fits || cmd.len[CNT_W-1:0] > fill_r))) begin
            status = STATUS_REJECT;
          end else begin
            tgt_addr_nxt = cmd.dev;
            tgt_reg_nxt  = cmd.reg_addr;
            is_read_nxt  = (cmd.op == OP_BEGIN_RD);
            xfer_len_nxt = cmd.len;
            byte_cnt_nxt = '0;
            rd_ptr_nxt   = '0;
            wait_cnt_nxt = '0;
            failed_nxt   = 1'b0;
            stage_nxt    = ST_ADDR_W;
            phase_nxt    = PH_START1;
          end
        end
        OP_LOAD: begin
          if (phase_r != PH_IDLE || fill_r >= CNT_W'(WRITE_DEPTH)) begin
            status = STATUS_REJECT;
          end else begin
            buf_we   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        default: begin
          case (phase_r)
            PH_START1: begin
              sda_nxt   = 1'b0;
              scl_nxt   = 1'b1;
              phase_nxt = PH_START2;
            end
            PH_START2: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {tgt_addr_r, 1'b0};
              bit_cnt_nxt = '0;
              stage_nxt   = ST_ADDR_W;
              phase_nxt   = PH_TX_BIT;
            end
            PH_TX_BIT: begin
              sda_nxt   = shift_r[BYTE_W-1];
              phase_nxt = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_TX_LOW;
            end
            PH_TX_LOW: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
              bit_cnt_nxt = bit_inc;
              phase_nxt   = (bit_inc >= 4'd8) ? PH_ACK_REL : PH_TX_BIT;
            end
            PH_ACK_REL: begin
              sda_nxt      = 1'b1;
              wait_cnt_nxt = '0;
              phase_nxt    = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_ACK_WAIT;
            end
            PH_ACK_WAIT: begin
              if (!cmd.sda) begin
                scl_nxt = 1'b0;
                case (stage_r)
                  ST_ADDR_W: begin
                    shift_nxt   = tgt_reg_r;
                    bit_cnt_nxt = '0;
                    stage_nxt   = ST_REG;
                    phase_nxt   = PH_TX_BIT;
                  end
                  ST_ADDR_R: begin
                    if (xfer_len_r == '0) begin
                      phase_nxt = PH_STOP1;
                    end else begin
                      bit_cnt_nxt = '0;
                      shift_nxt   = '0;
                      phase_nxt   = PH_RX_LOW;
                    end
                  end
                  default: begin
                    if (stage_r == ST_DATA) begin
                      byte_cnt_nxt = bc_inc;
                      rd_ptr_nxt   = ptr_inc;
                    end
                    if (stage_r == ST_REG && is_read_r) begin
                      phase_nxt = PH_RS1;
                    end else if (avail) begin
                      shift_nxt   = buf_rd;
                      bit_cnt_nxt = '0;
                      stage_nxt   = ST_DATA;
                      phase_nxt   = PH_TX_BIT;
                    end else begin
                      phase_nxt = PH_STOP1;
                    end
                  end
                endcase
              end else if (wait_cnt_r >= ack_timeout_r) begin
                failed_nxt = 1'b1;
                phase_nxt  = PH_STOP1;
              end else begin
                wait_cnt_nxt = wait_cnt_r + BYTE_W'(1);
              end
            end
            PH_RS1: begin
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b0;
              phase_nxt = PH_RS2;
            end
            PH_RS2: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_RS3;
            end
            PH_RS3: begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_RS4;
            end
            PH_RS4: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {tgt_addr_r, 1'b1};
              bit_cnt_nxt = '0;
              stage_nxt   = ST_ADDR_R;
              phase_nxt   = PH_TX_BIT;
            end
            PH_RX_LOW: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_RX_SAMPLE;
            end
            PH_RX_SAMPLE: begin
              shift_nxt   = {shift_r[BYTE_W-2:0], cmd.sda};
              bit_cnt_nxt = bit_inc;
              phase_nxt   = (bit_inc >= 4'd8) ? PH_MACK_DRIVE : PH_RX_LOW;
            end
            PH_MACK_DRIVE: begin
              scl_nxt   = 1'b0;
              sda_nxt   = last_byte;
              rbyte     = shift_r;
              rvalid    = 1'b1;
              rlast     = last_byte;
              phase_nxt = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_MACK_LOW;
            end
            PH_MACK_LOW: begin
              scl_nxt      = 1'b0;
              byte_cnt_nxt = bc_inc;
              bit_cnt_nxt  = '0;
              shift_nxt    = '0;
              phase_nxt    = (bc_inc >= xfer_len_r) ? PH_STOP1 : PH_RX_LOW;
            end
            PH_STOP1: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP2;
            end
            PH_STOP2: begin
              scl_nxt   = 1'b1;
              phase_nxt = PH_STOP3;
            end
            PH_STOP3: begin
              sda_nxt = 1'b1;
              status  = failed_r ? STATUS_TIMEOUT : STATUS_OK;
              if (!is_read_r) begin
                fill_nxt   = '0;
                rd_ptr_nxt = '0;
              end
              failed_nxt = 1'b0;
              phase_nxt  = PH_IDLE;
            end
            default: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      stage_r       <= ST_ADDR_W;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      byte_cnt_r    <= '0;
      wait_cnt_r    <= '0;
      fill_r        <= '0;
      rd_ptr_r      <= '0;
      tgt_addr_r    <= '0;
      tgt_reg_r     <= '0;
      is_read_r     <= 1'b0;
      xfer_len_r    <= '0;
      failed_r      <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      stage_r    <= stage_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      fill_r     <= fill_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      tgt_addr_r <= tgt_addr_nxt;
      tgt_reg_r  <= tgt_reg_nxt;
      is_read_r  <= is_read_nxt;
      xfer_len_r <= xfer_len_nxt;
      failed_r   <= failed_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      if (cfg_valid) begin
        ack_timeout_r <= cfg_data;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rbyte_r  <= rbyte;
      rvalid_r <= rvalid;
      rlast_r  <= rlast;
      status_r <= status;
      busy_r   <= (phase_nxt != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[fill_r[BUF_AW-1:0]] <= cmd.wbyte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = scl_r;
  assign out_sda_level  = sda_r;
  assign out_busy_res   = busy_r;
  assign out_read_byte  = rbyte_r;
  assign out_read_valid = rvalid_r;
  assign out_read_last  = rlast_r;
  assign out_status     = status_r;

endmodule

[src/i2c_master_register_access.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master for register reads and writes, one bus phase per tick beat.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in_     | in_valid/in_ready + item fields  | beat in, one per item
//  out_    | out_valid/out_ready + results    | beat out, one per item
//  cfg_    | cfg_valid/cfg_ready + cfg_data   | ack timeout write, always ready
//
//  One item per clock unless out_ready stalls; beats are queued then registered.
//  Rate is set by the engine, which retires one queued command per cycle.
//  Synchronous active-low reset; SCL/SDA come out of reset released high.
//  A stalled out_ready holds the result register; the two-entry queue
//  absorbs the backlog and in_ready drops only when it is full.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [i2cm_pkg::KIND_W-1:0] in_kind,
  input  logic                        in_sda_in,
  input  logic [i2cm_pkg::DEV_W-1:0]  in_dev_address,
  input  logic [i2cm_pkg::BYTE_W-1:0] in_reg_address,
  input  logic [i2cm_pkg::LEN_W-1:0]  in_length,
  input  logic [i2cm_pkg::BYTE_W-1:0] in_write_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_scl_level,
  output logic                        out_sda_level,
  output logic                        out_busy_res,
  output logic [i2cm_pkg::BYTE_W-1:0] out_read_byte,
  output logic                        out_read_valid,
  output logic                        out_read_last,
  output logic [i2cm_pkg::STAT_W-1:0] out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [i2cm_pkg::BYTE_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_in;
  cmd_t q_out;

  i2cm_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_sda_in      (in_sda_in),
    .in_dev_address (in_dev_address),
    .in_reg_address (in_reg_address),
    .in_length      (in_length),
    .in_write_byte  (in_write_byte),
    .q_full         (q_full),
    .push           (q_push),
    .push_data      (q_in)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  i2cm_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_not_empty),
    .cmd            (q_out),
    .cmd_pop        (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_busy_res   (out_busy_res),
    .out_read_byte  (out_read_byte),
    .out_read_valid (out_read_valid),
    .out_read_last  (out_read_last),
    .out_status     (out_status)
  );

endmodule

[src/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level assertions for the I2C register-access master.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [i2cm_pkg::KIND_W-1:0] in_kind,
  input logic                        in_sda_in,
  input logic [i2cm_pkg::DEV_W-1:0]  in_dev_address,
  input logic [i2cm_pkg::BYTE_W-1:0] in_reg_address,
  input logic [i2cm_pkg::LEN_W-1:0]  in_length,
  input logic [i2cm_pkg::BYTE_W-1:0] in_write_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_scl_level,
  input logic                        out_sda_level,
  input logic                        out_busy_res,
  input logic [i2cm_pkg::BYTE_W-1:0] out_read_byte,
  input logic                        out_read_valid,
  input logic                        out_read_last,
  input logic [i2cm_pkg::STAT_W-1:0] out_status,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [i2cm_pkg::BYTE_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_read_byte) && $stable(out_scl_level) && $stable(out_sda_level))
    else $error("result beat changed while stalled");

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_last |-> out_read_valid)
    else $error("read_last without read_valid");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_busy_res && !out_scl_level && out_status == STATUS_NONE)
    else $error("received byte outside a transfer");

  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK || out_status == STATUS_TIMEOUT) |->
      !out_busy_res && out_scl_level && out_sda_level)
    else $error("transfer end without STOP on the bus");

  a_byte_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |-> out_read_byte == '0)
    else $error("read_byte nonzero without read_valid");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (.*);
